// ===== rtl/ilp_pkg.sv =====
package ilp_pkg;

    // Character codes used by the scanners
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Decimal range limits: largest magnitude that may still take a digit,
    // and the magnitude of the most negative value
    localparam logic [63:0] DEC_LIMIT = 64'd922337203685477580;
    localparam logic [63:0] DEC_TOP   = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        MODE_DEC = 2'd0,
        MODE_HEX = 2'd1,
        MODE_BIN = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_ZERO  = 3'd2,
        PH_XPEND = 3'd3,
        PH_DIG   = 3'd4,
        PH_DONE  = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic        neg;
        logic        got;
        logic        ovf;
        logic [63:0] mag;
    } t_scan;

    typedef struct packed {
        logic       vld;
        logic [3:0] val;
    } t_digit;

    // Decode one character as a decimal or hex digit
    function automatic t_digit digit_val(input logic [7:0] c, input logic hex);
        t_digit d;
        d.vld = 1'b0;
        d.val = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d.vld = 1'b1;
            d.val = 4'(c - CH_0);
        end else if (hex && c >= CH_LO_A && c <= CH_LO_F) begin
            d.vld = 1'b1;
            d.val = 4'(c - CH_LO_A + 8'd10);
        end else if (hex && c >= CH_UP_A && c <= CH_UP_F) begin
            d.vld = 1'b1;
            d.val = 4'(c - CH_UP_A + 8'd10);
        end
        return d;
    endfunction

    // Shift one digit into the magnitude, flag overflow once
    function automatic t_scan accumulate(input t_scan s, input logic [3:0] d,
                                         input logic hex);
        t_scan       r;
        logic [63:0] n;
        r = s;
        n = {s.mag[60:0], 3'b000} + {s.mag[62:0], 1'b0} + {60'd0, d};
        if (!s.ovf) begin
            if (hex) begin
                if (s.mag[63:60] != 4'd0) r.ovf = 1'b1;
                else r.mag = {s.mag[59:0], d};
            end else begin
                if (s.mag > DEC_LIMIT) r.ovf = 1'b1;
                else if (n > DEC_TOP) r.ovf = 1'b1;
                else r.mag = n;
            end
        end
        return r;
    endfunction

    // First character after whitespace and sign
    function automatic t_scan first_digit(input t_scan s, input logic [7:0] c,
                                          input logic hex);
        t_scan  r;
        t_digit d;
        r = s;
        d = digit_val(c, hex);
        if (hex && c == CH_0) begin
            r.got   = 1'b1;
            r.phase = PH_ZERO;
        end else if (d.vld) begin
            r       = accumulate(s, d.val, hex);
            r.got   = 1'b1;
            r.phase = PH_DIG;
        end else begin
            r.phase = PH_DONE;
        end
        return r;
    endfunction

    // Advance a scanner by one character
    function automatic t_scan feed(input t_scan s, input logic [7:0] c,
                                   input logic hex);
        t_scan  r;
        t_digit d;
        r = s;
        d = digit_val(c, hex);
        case (s.phase)
            PH_LEAD: begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                    r = s;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    r.neg   = (c == CH_MINUS);
                    r.phase = PH_SIGN;
                end else begin
                    r = first_digit(s, c, hex);
                end
            end
            PH_SIGN: r = first_digit(s, c, hex);
            PH_ZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    r.phase = PH_XPEND;
                end else if (d.vld) begin
                    r       = accumulate(s, d.val, hex);
                    r.phase = PH_DIG;
                end else begin
                    r.phase = PH_DONE;
                end
            end
            PH_XPEND, PH_DIG: begin
                if (d.vld) begin
                    r       = accumulate(s, d.val, hex);
                    r.phase = PH_DIG;
                end else begin
                    r.phase = PH_DONE;
                end
            end
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/integer_literal_parser.sv =====
// Integer literal parser. Send the literal one byte per request and mark the
// last request with i_final_item; one result (o_parse_ok, o_parsed_value)
// follows for it. "0x"/"0X" with more text is hex (unsigned range, a minus sign
// wraps), "0b"/"0B" with more text is binary (low 64 bits kept), anything else
// is signed decimal with a 64-bit range check. One request is taken every
// clock unless a final one waits on a stalled result; the path is three
// register stages (input, scanner select, range check and negate).
// The scanner update, a shift-add by ten and its range compare, sets the clock.
module integer_literal_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_text_char,
    input  logic               i_char_present,
    input  logic               i_final_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_parse_ok,
    output logic signed [63:0] o_parsed_value
);
    import ilp_pkg::*;

    // Input stage
    logic              r_in_vld;
    logic [7:0]        r_in_char;
    logic              r_in_present;
    logic              r_in_final;

    // Scanner state
    logic [1:0]        r_pos,        n_pos;
    logic              r_first_zero, n_first_zero;
    t_mode             r_pfx,        n_pfx;
    t_mode             r_mode,       n_mode;
    t_scan             r_dec,        n_dec;
    t_scan             r_hex,        n_hex;
    logic [63:0]       r_bin,        n_bin;
    logic              r_bin_bad,    n_bin_bad;

    // Finish stage
    logic              r_fin_vld;
    logic              r_fin_ok,     n_fin_ok;
    logic              r_fin_neg,    n_fin_neg;
    logic              r_fin_dec,    n_fin_dec;
    logic [63:0]       r_fin_mag,    n_fin_mag;

    // Output stage
    logic              r_out_vld;
    logic              r_out_ok,     n_out_ok;
    logic [63:0]       r_out_val,    n_out_val;

    t_mode             cur_mode;
    logic              out_take;
    logic              fin_take;
    logic              consume;

    // Stall chain
    assign out_take = !r_out_vld || i_ready;
    assign fin_take = !r_fin_vld || out_take;
    assign consume  = r_in_vld && (!r_in_final || fin_take);
    assign o_ready  = !r_in_vld || consume;

    // Mode in force for the current character
    assign cur_mode = (r_pos == 2'd2) ? r_pfx : r_mode;

    // Advance the scanners by one character
    always_comb begin
        n_pos        = r_pos;
        n_first_zero = r_first_zero;
        n_pfx        = r_pfx;
        n_mode       = r_mode;
        n_dec        = r_dec;
        n_hex        = r_hex;
        n_bin        = r_bin;
        n_bin_bad    = r_bin_bad;
        if (r_in_present) begin
            unique case (r_pos)
                2'd0: n_first_zero = (r_in_char == CH_0);
                2'd1: begin
                    if (r_first_zero && (r_in_char == CH_LO_X || r_in_char == CH_UP_X))
                        n_pfx = MODE_HEX;
                    else if (r_first_zero &&
                             (r_in_char == CH_LO_B || r_in_char == CH_UP_B))
                        n_pfx = MODE_BIN;
                    else
                        n_pfx = MODE_DEC;
                end
                2'd2: n_mode = r_pfx;
                2'd3: n_mode = r_mode;
            endcase
            if (cur_mode == MODE_HEX) begin
                n_hex = feed(r_hex, r_in_char, 1'b1);
            end else if (cur_mode == MODE_BIN) begin
                if (r_in_char == CH_0 || r_in_char == CH_1)
                    n_bin = {r_bin[62:0], r_in_char[0]};
                else
                    n_bin_bad = 1'b1;
            end else begin
                n_dec = feed(r_dec, r_in_char, 1'b0);
            end
            if (r_pos != 2'd3) n_pos = r_pos + 2'd1;
        end
    end

    // Pick the scanner that the mode selects
    always_comb begin
        if (n_mode == MODE_HEX) begin
            n_fin_ok  = n_hex.got && !n_hex.ovf;
            n_fin_neg = n_hex.neg;
            n_fin_dec = 1'b0;
            n_fin_mag = n_hex.mag;
        end else if (n_mode == MODE_BIN) begin
            n_fin_ok  = !n_bin_bad;
            n_fin_neg = 1'b0;
            n_fin_dec = 1'b0;
            n_fin_mag = n_bin;
        end else begin
            n_fin_ok  = n_dec.got && !n_dec.ovf;
            n_fin_neg = n_dec.neg;
            n_fin_dec = 1'b1;
            n_fin_mag = n_dec.mag;
        end
    end

    // Range check for decimal and apply the sign
    always_comb begin
        n_out_ok = r_fin_ok &&
                   (!r_fin_dec || (r_fin_neg ? (r_fin_mag <= DEC_TOP)
                                             : (r_fin_mag < DEC_TOP)));
        if (!n_out_ok)      n_out_val = 64'd0;
        else if (r_fin_neg) n_out_val = 64'd0 - r_fin_mag;
        else                n_out_val = r_fin_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_pos        <= 2'd0;
            r_first_zero <= 1'b0;
            r_pfx        <= MODE_DEC;
            r_mode       <= MODE_DEC;
            r_dec        <= '0;
            r_hex        <= '0;
            r_bin        <= 64'd0;
            r_bin_bad    <= 1'b0;
            r_fin_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            // Capture the request
            if (o_ready) r_in_vld <= i_valid;

            // Update scanners; clear them after the final character
            if (consume) begin
                if (r_in_final) begin
                    r_pos        <= 2'd0;
                    r_first_zero <= 1'b0;
                    r_pfx        <= MODE_DEC;
                    r_mode       <= MODE_DEC;
                    r_dec        <= '0;
                    r_hex        <= '0;
                    r_bin        <= 64'd0;
                    r_bin_bad    <= 1'b0;
                end else begin
                    r_pos        <= n_pos;
                    r_first_zero <= n_first_zero;
                    r_pfx        <= n_pfx;
                    r_mode       <= n_mode;
                    r_dec        <= n_dec;
                    r_hex        <= n_hex;
                    r_bin        <= n_bin;
                    r_bin_bad    <= n_bin_bad;
                end
            end

            if (fin_take) r_fin_vld <= consume && r_in_final;
            if (out_take) r_out_vld <= r_fin_vld;
        end

        // Payload registers
        if (o_ready && i_valid) begin
            r_in_char    <= i_text_char;
            r_in_present <= i_char_present;
            r_in_final   <= i_final_item;
        end
        if (fin_take && consume && r_in_final) begin
            r_fin_ok  <= n_fin_ok;
            r_fin_neg <= n_fin_neg;
            r_fin_dec <= n_fin_dec;
            r_fin_mag <= n_fin_mag;
        end
        if (out_take && r_fin_vld) begin
            r_out_ok  <= n_out_ok;
            r_out_val <= n_out_val;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_parse_ok     = r_out_ok;
    assign o_parsed_value = signed'(r_out_val);

endmodule

// ===== rtl/ilp_checker.sv =====
module ilp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [7:0]         i_text_char,
    input logic               i_char_present,
    input logic               i_final_item,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_parse_ok,
    input logic signed [63:0] o_parsed_value
);

    // Count final requests taken whose results are not yet delivered
    logic [2:0] r_pending;
    logic       in_fin;
    logic       out_done;

    assign in_fin   = i_valid && o_ready && i_final_item;
    assign out_done = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 3'd0;
        end else begin
            r_pending <= r_pending + {2'd0, in_fin} - {2'd0, out_done};
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_parse_ok) &&
                                 $stable(o_parsed_value))
        else $error("stalled result changed");

    // Drop the value on a failed parse
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_parse_ok |-> o_parsed_value == 64'sd0)
        else $error("failed parse with nonzero value");

    // No result without a final request behind it
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != 3'd0)
        else $error("result without a final request");

    // At most three finals in flight
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd3)
        else $error("too many results pending");

endmodule

bind integer_literal_parser ilp_checker u_ilp_checker (.*);

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ilp_pkg::*;

    // Scanner state for the hex and decimal readers
    typedef struct packed {
        t_phase      ph;
        logic        minus;
        logic        any;
        logic        over;
        logic [63:0] mag;
    } t_num_scan;

    typedef struct packed {
        logic        ok;
        logic [63:0] value;
    } t_parse_result;

    // One literal of the directed part; fixed rows carry their own result
    typedef struct {
        string       txt;
        bit          empty_end;
        bit          fixed;
        bit          ok;
        logic [63:0] value;
    } t_lit_row;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_ready;
    logic [7:0]         i_text_char    = 8'd0;
    logic               i_char_present = 1'b0;
    logic               i_final_item   = 1'b0;
    logic               o_valid;
    logic               i_ready        = 1'b0;
    logic               o_parse_ok;
    logic signed [63:0] o_parsed_value;

    t_parse_result pending_literals[$];
    int unsigned   mismatch_count = 0;
    bit            calm           = 1'b0;

    // Literal tracking state, cleared after every final request
    logic [1:0]  seen_chars    = 2'd0;
    bit          starts_zero   = 1'b0;
    t_mode       prefix_mode   = MODE_DEC;
    t_mode       radix_mode    = MODE_DEC;
    t_num_scan   dec_scan_st   = '0;
    t_num_scan   hex_scan_st   = '0;
    logic [63:0] bin_bits      = 64'd0;
    bit          bin_bad_digit = 1'b0;

    t_lit_row directed_rows [20] = '{
        '{"",                       1'b1, 1'b1, 1'b0, 64'd0},
        '{"0",                      1'b0, 1'b1, 1'b1, 64'd0},
        '{"9223372036854775807",    1'b0, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF},
        '{"-9223372036854775808",   1'b0, 1'b1, 1'b1, 64'h8000_0000_0000_0000},
        '{"9223372036854775808",    1'b0, 1'b1, 1'b0, 64'd0},
        '{"-99999999999999999999",  1'b0, 1'b1, 1'b0, 64'd0},
        '{"0xFFFFFFFFFFFFFFFF",     1'b0, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{"0x10000000000000000",    1'b0, 1'b1, 1'b0, 64'd0},
        '{"0b101",                  1'b0, 1'b1, 1'b1, 64'd5},
        '{"0B1021",                 1'b0, 1'b1, 1'b0, 64'd0},
        '{"0x",                     1'b0, 1'b1, 1'b1, 64'd0},
        '{"0b",                     1'b0, 1'b1, 1'b1, 64'd0},
        '{"+",                      1'b0, 1'b1, 1'b0, 64'd0},
        '{"0xg",                    1'b0, 1'b1, 1'b0, 64'd0},
        '{" \t\n-42 apples",        1'b0, 1'b0, 1'b0, 64'd0},
        '{"0x-0x1f",                1'b0, 1'b0, 1'b0, 64'd0},
        '{"0x0xg",                  1'b0, 1'b0, 1'b0, 64'd0},
        '{"0x+aBcD",                1'b0, 1'b0, 1'b0, 64'd0},
        '{"0X  -1",                 1'b0, 1'b0, 1'b0, 64'd0},
        '{"12",                     1'b1, 1'b0, 1'b0, 64'd0}
    };

    integer_literal_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_char    (i_text_char),
        .i_char_present (i_char_present),
        .i_final_item   (i_final_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_parse_ok     (o_parse_ok),
        .o_parsed_value (o_parsed_value)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Idle cycles before the next request or result; none during calm stretches
    function automatic int unsigned wait_draw();
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    // Digit value of a byte, or -1
    function automatic int char_digit(input logic [7:0] c, input bit hex_ok);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (hex_ok && c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
        if (hex_ok && c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
        return -1;
    endfunction

    // Append one digit to the magnitude; latch overflow
    function automatic t_num_scan take_digit(input t_num_scan s, input logic [3:0] d,
                                             input bit hex_ok);
        logic [63:0] nxt;
        if (s.over) return s;
        if (hex_ok) begin
            if (s.mag[63:60] != 4'd0) s.over = 1'b1;
            else s.mag = {s.mag[59:0], d};
        end else if (s.mag > DEC_LIMIT) begin
            s.over = 1'b1;
        end else begin
            nxt = s.mag * 64'd10 + 64'(d);
            if (nxt > DEC_TOP) s.over = 1'b1;
            else s.mag = nxt;
        end
        return s;
    endfunction

    // First byte after blanks and sign
    function automatic t_num_scan open_digits(input t_num_scan s, input logic [7:0] c,
                                              input bit hex_ok);
        int d;
        d = char_digit(c, hex_ok);
        if (hex_ok && c == CH_0) begin
            s.any = 1'b1;
            s.ph  = PH_ZERO;
        end else if (d >= 0) begin
            s.any = 1'b1;
            s     = take_digit(s, 4'(d), hex_ok);
            s.ph  = PH_DIG;
        end else begin
            s.ph = PH_DONE;
        end
        return s;
    endfunction

    // Advance a scanner by one byte
    function automatic t_num_scan scan_char(input t_num_scan s, input logic [7:0] c,
                                            input bit hex_ok);
        int d;
        d = char_digit(c, hex_ok);
        case (s.ph)
            PH_LEAD: begin
                if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        s.minus = (c == CH_MINUS);
                        s.ph    = PH_SIGN;
                    end else begin
                        s = open_digits(s, c, hex_ok);
                    end
                end
            end
            PH_SIGN: s = open_digits(s, c, hex_ok);
            PH_ZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    s.ph = PH_XPEND;
                end else if (d >= 0) begin
                    s    = take_digit(s, 4'(d), hex_ok);
                    s.ph = PH_DIG;
                end else begin
                    s.ph = PH_DONE;
                end
            end
            PH_XPEND, PH_DIG: begin
                if (d >= 0) begin
                    s    = take_digit(s, 4'(d), hex_ok);
                    s.ph = PH_DIG;
                end else begin
                    s.ph = PH_DONE;
                end
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    // Track one accepted request; give the literal's result on the final one
    task automatic parse_literal_byte(input logic [7:0] c, input bit has_char,
                                      input bit last, output bit has_res,
                                      output t_parse_result res);
        bit          ok;
        logic [63:0] val;
        has_res = 1'b0;
        res     = '0;
        if (has_char) begin
            case (seen_chars)
                2'd0: starts_zero = (c == CH_0);
                2'd1: begin
                    if (starts_zero && (c == CH_LO_X || c == CH_UP_X)) prefix_mode = MODE_HEX;
                    else if (starts_zero && (c == CH_LO_B || c == CH_UP_B))
                        prefix_mode = MODE_BIN;
                    else prefix_mode = MODE_DEC;
                end
                2'd2: radix_mode = prefix_mode;
                default: begin
                end
            endcase
            if (radix_mode == MODE_HEX) begin
                hex_scan_st = scan_char(hex_scan_st, c, 1'b1);
            end else if (radix_mode == MODE_BIN) begin
                if (c == CH_0 || c == CH_1) bin_bits = {bin_bits[62:0], c[0]};
                else bin_bad_digit = 1'b1;
            end else begin
                dec_scan_st = scan_char(dec_scan_st, c, 1'b0);
            end
            if (seen_chars != 2'd3) seen_chars = seen_chars + 2'd1;
        end
        if (last) begin
            if (radix_mode == MODE_HEX) begin
                ok  = hex_scan_st.any && !hex_scan_st.over;
                val = hex_scan_st.minus ? -hex_scan_st.mag : hex_scan_st.mag;
            end else if (radix_mode == MODE_BIN) begin
                ok  = !bin_bad_digit;
                val = bin_bits;
            end else begin
                ok  = dec_scan_st.any && !dec_scan_st.over &&
                      (dec_scan_st.minus ? dec_scan_st.mag <= DEC_TOP
                                         : dec_scan_st.mag < DEC_TOP);
                val = dec_scan_st.minus ? -dec_scan_st.mag : dec_scan_st.mag;
            end
            has_res   = 1'b1;
            res.ok    = ok;
            res.value = ok ? val : 64'd0;
            // Start the next literal from scratch
            seen_chars    = 2'd0;
            starts_zero   = 1'b0;
            prefix_mode   = MODE_DEC;
            radix_mode    = MODE_DEC;
            dec_scan_st   = '0;
            hex_scan_st   = '0;
            bin_bits      = 64'd0;
            bin_bad_digit = 1'b0;
        end
    endtask

    // Drive one request and hold it until taken; queue its result if any
    task automatic push_request(input logic [7:0] c, input bit has_char, input bit last,
                                input bit fixed, input bit fixed_ok,
                                input logic [63:0] fixed_value);
        int unsigned   gap;
        bit            has_res;
        t_parse_result res;
        gap = wait_draw();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_text_char    <= c;
        i_char_present <= has_char;
        i_final_item   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        parse_literal_byte(c, has_char, last, has_res, res);
        if (has_res) begin
            if (fixed) begin
                res.ok    = fixed_ok;
                res.value = fixed_value;
            end
            pending_literals = {pending_literals, res};
        end
    endtask

    // Stimulus: reset, directed literals, then random literals
    initial begin
        logic [7:0]  lit_bytes[$];
        int unsigned n;
        int unsigned sent_items;
        bit          empty_end;
        string       top_digits;
        string       hex_set;
        top_digits = "922337203685477580";
        hex_set    = "0123456789abcdefABCDEF";
        sent_items = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int i = 0; i < directed_rows[r].txt.len(); i++) begin
                push_request(directed_rows[r].txt[i], 1'b1,
                             (i == directed_rows[r].txt.len() - 1) && !directed_rows[r].empty_end,
                             directed_rows[r].fixed, directed_rows[r].ok,
                             directed_rows[r].value);
                sent_items++;
            end
            if (directed_rows[r].empty_end) begin
                push_request(8'hFF, 1'b0, 1'b1, directed_rows[r].fixed,
                             directed_rows[r].ok, directed_rows[r].value);
                sent_items++;
            end
        end

        while (sent_items < 600) begin
            lit_bytes.delete();
            if ($urandom_range(0, 11) == 0) calm = !calm;
            case ($urandom_range(0, 9))
                // Decimal: blanks, sign, digits (some near the range edge), junk
                0, 1, 2: begin
                    repeat ($urandom_range(0, 2)) begin
                        n = $urandom_range(8, 13);
                        lit_bytes = {lit_bytes, (n == 8 ? CH_SPACE : 8'(n))};
                    end
                    case ($urandom_range(0, 3))
                        0: lit_bytes = {lit_bytes, CH_PLUS};
                        1: lit_bytes = {lit_bytes, CH_MINUS};
                        default: begin
                        end
                    endcase
                    if ($urandom_range(0, 3) == 0) begin
                        for (int i = 0; i < top_digits.len(); i++)
                            lit_bytes = {lit_bytes, top_digits[i]};
                        repeat ($urandom_range(1, 2))
                            lit_bytes = {lit_bytes, CH_0 + 8'($urandom_range(0, 9))};
                    end else begin
                        repeat ($urandom_range(1, 20))
                            lit_bytes = {lit_bytes, CH_0 + 8'($urandom_range(0, 9))};
                    end
                    if ($urandom_range(0, 2) == 0)
                        lit_bytes = {lit_bytes, 8'($urandom_range(0, 255))};
                end
                // Hex: prefix, blanks, sign, repeated prefix, digits, junk
                3, 4, 5: begin
                    lit_bytes = {lit_bytes, CH_0};
                    lit_bytes = {lit_bytes, ($urandom_range(0, 1) ? CH_LO_X : CH_UP_X)};
                    if ($urandom_range(0, 5) == 0) lit_bytes = {lit_bytes, CH_SPACE};
                    case ($urandom_range(0, 3))
                        0: lit_bytes = {lit_bytes, CH_PLUS};
                        1: lit_bytes = {lit_bytes, CH_MINUS};
                        default: begin
                        end
                    endcase
                    if ($urandom_range(0, 3) == 0) begin
                        lit_bytes = {lit_bytes, CH_0};
                        lit_bytes = {lit_bytes, ($urandom_range(0, 1) ? CH_LO_X : CH_UP_X)};
                    end
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 17)
                                                    : $urandom_range(1, 14);
                    repeat (n) lit_bytes = {lit_bytes, hex_set[$urandom_range(0, 21)]};
                    if ($urandom_range(0, 2) == 0)
                        lit_bytes = {lit_bytes, 8'($urandom_range(0, 255))};
                end
                // Binary: mostly short, a few past 64 bits, some with a bad digit
                6, 7: begin
                    lit_bytes = {lit_bytes, CH_0};
                    lit_bytes = {lit_bytes, ($urandom_range(0, 1) ? CH_LO_B : CH_UP_B)};
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(1, 16);
                    repeat (n) lit_bytes = {lit_bytes, ($urandom_range(0, 1) ? CH_1 : CH_0)};
                    if ($urandom_range(0, 5) == 0)
                        lit_bytes[$urandom_range(2, lit_bytes.size() - 1)] =
                            8'($urandom_range(0, 255));
                end
                // Short text: bare prefixes, one byte, or nothing
                8: begin
                    case ($urandom_range(0, 3))
                        0: begin
                            lit_bytes = {lit_bytes, CH_0};
                            lit_bytes = {lit_bytes,
                                         ($urandom_range(0, 1) ? CH_LO_X : CH_UP_X)};
                        end
                        1: begin
                            lit_bytes = {lit_bytes, CH_0};
                            lit_bytes = {lit_bytes,
                                         ($urandom_range(0, 1) ? CH_LO_B : CH_UP_B)};
                        end
                        2: lit_bytes = {lit_bytes, 8'($urandom_range(0, 255))};
                        default: begin
                        end
                    endcase
                end
                // Noise bytes
                default: begin
                    repeat ($urandom_range(1, 6))
                        lit_bytes = {lit_bytes, 8'($urandom_range(0, 255))};
                end
            endcase

            empty_end = (lit_bytes.size() == 0) || ($urandom_range(0, 5) == 0);
            foreach (lit_bytes[i]) begin
                // Sprinkle in empty requests that carry no byte and are dropped
                if ($urandom_range(0, 9) == 0) begin
                    push_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 1'b0, 64'd0);
                    sent_items++;
                end
                push_request(lit_bytes[i], 1'b1,
                             (i == lit_bytes.size() - 1) && !empty_end, 1'b0, 1'b0, 64'd0);
                sent_items++;
            end
            if (empty_end) begin
                push_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 1'b0, 64'd0);
                sent_items++;
            end
        end
        i_valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (pending_literals.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Result side: stall at random, check each result against the oldest expectation
    initial begin
        int unsigned   stall;
        t_parse_result want;
        repeat (7) @(posedge i_clk);
        forever begin
            stall = wait_draw();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (pending_literals.size() == 0) begin
                $display("%0t: unexpected result ok=%0b value=%h", $time, o_parse_ok,
                         o_parsed_value);
                mismatch_count++;
            end else begin
                want = pending_literals.pop_front();
                if (o_parse_ok !== want.ok) begin
                    $display("%0t: parse_ok expected %0b, got %0b", $time, want.ok,
                             o_parse_ok);
                    mismatch_count++;
                end
                if (o_parsed_value !== want.value) begin
                    $display("%0t: parsed_value expected %h, got %h", $time, want.value,
                             o_parsed_value);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
